// File: src/upk_pkg.sv
// ----------------------------------------------------------------------------
// upk_pkg
// Types, codes and channel helpers shared by the BMP row unpacker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package upk_pkg;

    localparam int CFG_DW  = 32;
    localparam int CFG_AW  = 3;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;

    typedef enum logic [2:0] {
        FMT_1BIT  = 3'd0,
        FMT_4BIT  = 3'd1,
        FMT_8BIT  = 3'd2,
        FMT_16BIT = 3'd3,
        FMT_24BIT = 3'd4,
        FMT_32BIT = 3'd5
    } fmt_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_PIXEL_FORMAT = 3'd0,
        REG_ROW_WIDTH    = 3'd1,
        REG_RED_MASK     = 3'd2,
        REG_GREEN_MASK   = 3'd3,
        REG_BLUE_MASK    = 3'd4,
        REG_ALPHA_MASK   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic [31:0] alpha;
    } masks_t;

    typedef struct packed {
        logic       left;
        logic [4:0] amt;
    } shift_t;

    // one request from front to back: the pixels of one byte, or one direct-color pixel
    typedef struct packed {
        logic [2:0]  fmt;
        logic [31:0] data;
        logic [2:0]  last_idx;
        logic        row_last;
    } q_entry_t;

    // right shift: smallest s with bit 7+s set and bit 8+s clear;
    // narrow masks shift left until the top bit reaches bit 7
    function automatic shift_t mask_shift(input logic [31:0] m);
        shift_t      r;
        logic [2:0]  msb;
        logic [32:0] mx;
        r.left = 1'b0;
        r.amt  = '0;
        msb    = '0;
        mx     = {1'b0, m};
        if (m[31:7] == '0) begin
            for (int i = 0; i < 7; i++) begin
                if (m[i]) begin
                    msb = 3'(i);
                end
            end
            if (m[6:0] != '0) begin
                r.left = 1'b1;
                r.amt  = {2'b00, 3'd7 - msb};
            end
        end else begin
            for (int s = 24; s >= 0; s--) begin
                if (mx[7+s] && !mx[8+s]) begin
                    r.amt = 5'(s);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] chan(input logic [31:0] c, input logic [31:0] m,
                                        input shift_t sh);
        logic [31:0] v;
        logic [31:0] t;
        v = c & m;
        if (sh.left) begin
            t = v << sh.amt;
        end else begin
            t = v >> sh.amt;
        end
        return t[7:0];
    endfunction

endpackage

`default_nettype wire

// File: src/upk_front.sv
// ----------------------------------------------------------------------------
// upk_front
// Accepts row bytes, tracks row position and pixel assembly, queues requests.
// ----------------------------------------------------------------------------
`default_nettype none

module upk_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         data_byte,
    input  wire logic [2:0]         pixel_format,
    input  wire logic [12:0]        row_width,
    output logic                    q_push,
    output upk_pkg::q_entry_t       q_entry
);
    import upk_pkg::*;

    localparam int PW = ($clog2(4 * MAX_WIDTH) < 1) ? 1 : $clog2(4 * MAX_WIDTH);
    localparam int LW = PW + 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = LW + 3;

    logic [PW-1:0] pos_reg, pos_next;
    logic [23:0]   coll_reg, coll_next;
    logic [1:0]    cnt_reg, cnt_next;

    logic [WW-1:0] w;
    logic [LW-1:0] w_x, data_bytes, row_bytes, pos_x, pos_inc;
    logic [2:0]    bpp;
    logic [XW-1:0] rem8, rem2;
    logic          fmt_ok, in_data, collect;
    logic [31:0]   pix;

    always_comb
    begin
        if (row_width == '0) begin
            w = WW'(1);
        end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(row_width);
        end
        w_x     = LW'(w);
        pos_x   = LW'(pos_reg);
        pos_inc = pos_x + LW'(1);
        fmt_ok  = 1'b1;
        bpp     = 3'd1;
        case (pixel_format)
            FMT_1BIT:  data_bytes = (w_x + LW'(7)) >> 3;
            FMT_4BIT:  data_bytes = (w_x + LW'(1)) >> 1;
            FMT_8BIT:  data_bytes = w_x;
            FMT_16BIT:
            begin
                bpp        = 3'd2;
                data_bytes = w_x << 1;
            end
            FMT_24BIT:
            begin
                bpp        = 3'd3;
                data_bytes = w_x + (w_x << 1);
            end
            FMT_32BIT:
            begin
                bpp        = 3'd4;
                data_bytes = w_x << 2;
            end
            default:
            begin
                fmt_ok     = 1'b0;
                data_bytes = w_x;
            end
        endcase
        row_bytes = (data_bytes + LW'(3)) & ~LW'(3);
        in_data   = pos_x < data_bytes;
        rem8      = XW'(w) - (XW'(pos_reg) << 3);
        rem2      = XW'(w) - (XW'(pos_reg) << 1);
        collect   = ({1'b0, cnt_reg} < (bpp - 3'd1));

        case (pixel_format)
            FMT_16BIT: pix = {8'b0, coll_reg} | {16'b0, data_byte, 8'b0};
            FMT_24BIT: pix = {8'b0, coll_reg} | {8'b0, data_byte, 16'b0};
            default:   pix = {8'b0, coll_reg} | {data_byte, 24'b0};
        endcase

        q_push            = 1'b0;
        q_entry.fmt       = pixel_format;
        q_entry.data      = {24'b0, data_byte};
        q_entry.last_idx  = '0;
        q_entry.row_last  = 1'b0;
        coll_next         = coll_reg;
        cnt_next          = cnt_reg;
        pos_next          = pos_reg;

        if (accept && fmt_ok) begin
            if (in_data) begin
                case (pixel_format)
                    FMT_1BIT:
                    begin
                        q_push           = 1'b1;
                        q_entry.last_idx = (rem8 >= XW'(8)) ? 3'd7 : 3'(rem8 - XW'(1));
                        q_entry.row_last = rem8 <= XW'(8);
                    end
                    FMT_4BIT:
                    begin
                        q_push           = 1'b1;
                        q_entry.last_idx = (rem2 >= XW'(2)) ? 3'd1 : 3'd0;
                        q_entry.row_last = rem2 <= XW'(2);
                    end
                    FMT_8BIT:
                    begin
                        q_push           = 1'b1;
                        q_entry.row_last = pos_x == (w_x - LW'(1));
                    end
                    default:
                    begin
                        if (collect) begin
                            coll_next = coll_reg | (24'(data_byte) << {cnt_reg, 3'b000});
                            cnt_next  = cnt_reg + 2'd1;
                        end else begin
                            q_push           = 1'b1;
                            q_entry.data     = pix;
                            q_entry.row_last = pos_x >= (data_bytes - LW'(bpp));
                            coll_next        = '0;
                            cnt_next         = '0;
                        end
                    end
                endcase
            end
            if (pos_inc >= row_bytes) begin
                pos_next  = '0;
                coll_next = '0;
                cnt_next  = '0;
            end else begin
                pos_next = PW'(pos_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            coll_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            pos_reg  <= pos_next;
            coll_reg <= coll_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: src/upk_fifo.sv
// ----------------------------------------------------------------------------
// upk_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module upk_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire upk_pkg::q_entry_t  wr_data,
    input  wire logic               rd_en,
    output upk_pkg::q_entry_t       rd_data,
    output logic                    q_full,
    output logic                    q_valid
);
    import upk_pkg::*;

    q_entry_t         mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     cnt_reg, cnt_next;

    assign q_full  = cnt_reg == (QAW+1)'(QDEPTH);
    assign q_valid = cnt_reg != '0;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({wr_en, rd_en})
            2'b10:   cnt_next = cnt_reg + (QAW+1)'(1);
            2'b01:   cnt_next = cnt_reg - (QAW+1)'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: src/upk_back.sv
// ----------------------------------------------------------------------------
// upk_back
// Expands queued requests into pixels, extracts channels, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module upk_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire upk_pkg::masks_t    masks,
    input  wire logic               q_valid,
    input  wire upk_pkg::q_entry_t  head,
    output logic                    q_pop,
    output logic                    empty,
    input  wire logic               pop,
    output logic [7:0]              red_or_index,
    output logic [7:0]              green,
    output logic [7:0]              blue,
    output logic [7:0]              alpha,
    output logic                    row_last,
    output logic                    run_last
);
    import upk_pkg::*;

    shift_t     sh_r_reg, sh_g_reg, sh_b_reg, sh_a_reg;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic       row_last_reg, run_last_reg;
    logic [7:0] red_next, green_next, blue_next, alpha_next;
    logic       advance, is_last;
    logic [2:0] bit_sel;

    // shifts follow the mask registers; the user must change masks only while idle, the block does not enforce it
    always_ff @(posedge clk)
    begin
        sh_r_reg <= mask_shift(masks.red);
        sh_g_reg <= mask_shift(masks.green);
        sh_b_reg <= mask_shift(masks.blue);
        sh_a_reg <= mask_shift(masks.alpha);
    end

    assign advance = q_valid && (!out_valid_reg || pop);
    assign is_last = idx_reg == head.last_idx;
    assign q_pop   = advance && is_last;
    assign bit_sel = 3'd7 - idx_reg;

    always_comb
    begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        alpha_next = '0;
        case (head.fmt)
            FMT_1BIT:  red_next = {7'b0, head.data[bit_sel]};
            FMT_4BIT:  red_next = (idx_reg == '0) ? {4'b0, head.data[7:4]}
                                                  : {4'b0, head.data[3:0]};
            FMT_8BIT:  red_next = head.data[7:0];
            default:
            begin
                red_next   = chan(head.data, masks.red, sh_r_reg);
                green_next = chan(head.data, masks.green, sh_g_reg);
                blue_next  = chan(head.data, masks.blue, sh_b_reg);
                if (head.fmt == FMT_32BIT) begin
                    alpha_next = chan(head.data, masks.alpha, sh_a_reg);
                end
            end
        endcase

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !pop;
        if (advance) begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            red_reg      <= red_next;
            green_reg    <= green_next;
            blue_reg     <= blue_next;
            alpha_reg    <= alpha_next;
            row_last_reg <= head.row_last && is_last;
            run_last_reg <= is_last;
        end
    end

    assign empty        = !out_valid_reg;
    assign red_or_index = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = alpha_reg;
    assign row_last     = row_last_reg;
    assign run_last     = run_last_reg;

    a_row_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && row_last_reg) |-> run_last_reg)
        else $error("row_last without run_last");

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (idx_reg <= head.last_idx))
        else $error("pixel index past end of run");

    a_idx_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (idx_reg == 3'd0))
        else $error("pixel index not cleared after request done");

endmodule

`default_nettype wire

// File: src/bmp_row_pixel_unpacker_top.sv
// ----------------------------------------------------------------------------
// bmp_row_pixel_unpacker_top
// BMP pixel row unpacker: raw row bytes in, palette indices or RGBA out.
// ----------------------------------------------------------------------------
// One row byte is taken per cycle while full is low. Each byte yields 0 to 8
// pixels, and the back end emits one pixel per cycle while results are popped,
// so 8-bit and direct-color modes keep pace with the input, while 4-bit and
// 1-bit modes emit up to 2 and up to 8 pixels per byte and can fall behind;
// the 4-entry request queue between front and back absorbs short bursts before
// full rises. A completed pixel passes the queue and then the output register.
// Mask writes pass the mask registers and then the shift registers in the back end.
`default_nettype none

module bmp_row_pixel_unpacker_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [upk_pkg::CFG_AW-1:0] cfg_index,
    input  wire logic [upk_pkg::CFG_DW-1:0] cfg_data,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [7:0]                 data_byte,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [7:0]                      red_or_index,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic [7:0]                      alpha,
    output logic                            row_last,
    output logic                            run_last
);
    import upk_pkg::*;

    logic [2:0]  fmt_reg;
    logic [12:0] width_reg;
    masks_t      masks_reg;

    logic        accept, q_push, q_pop, q_full, q_valid;
    q_entry_t    q_wr, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fmt_reg         <= FMT_24BIT;
            width_reg       <= 13'd1;
            masks_reg.red   <= 32'h00FF0000;
            masks_reg.green <= 32'h0000FF00;
            masks_reg.blue  <= 32'h000000FF;
            masks_reg.alpha <= 32'h00000000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PIXEL_FORMAT: fmt_reg         <= cfg_data[2:0];
                REG_ROW_WIDTH:    width_reg       <= cfg_data[12:0];
                REG_RED_MASK:     masks_reg.red   <= cfg_data;
                REG_GREEN_MASK:   masks_reg.green <= cfg_data;
                REG_BLUE_MASK:    masks_reg.blue  <= cfg_data;
                REG_ALPHA_MASK:   masks_reg.alpha <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    upk_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .pixel_format (fmt_reg),
        .row_width    (width_reg),
        .q_push       (q_push),
        .q_entry      (q_wr)
    );

    upk_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .q_full  (q_full),
        .q_valid (q_valid)
    );

    upk_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .masks        (masks_reg),
        .q_valid      (q_valid),
        .head         (q_head),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .red_or_index (red_or_index),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .row_last     (row_last),
        .run_last     (run_last)
    );

endmodule

`default_nettype wire
